/* src/hkchd_pkg.sv */
// ----------------------------------------------------------------------------
// hkchd_pkg
// Types and constants for the hotkey combination hold detector.
// ----------------------------------------------------------------------------
package hkchd_pkg;

	localparam int MAX_KEYS   = 8;
	localparam int CODE_W     = 10;
	localparam int PAIR_W     = 2 * CODE_W;
	localparam int COUNT_W    = 4;
	localparam int HOLD_W     = 16;
	localparam int ETYPE_W    = 16;
	localparam int VALUE_W    = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 16;

	localparam logic [ETYPE_W-1:0] ETYPE_KEY = 16'd1;

	// item kinds on s_tuser; the fourth code carries no work
	typedef enum logic [1:0] {
		KIND_KEY  = 2'd0,
		KIND_TICK = 2'd1,
		KIND_SNAP = 2'd2
	} kind_t;

	// register indexes on the config channel
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS    = 3'd5;

	localparam logic [PAIR_W-1:0]  RST_KEY_PAIR_0 = 20'd68662;
	localparam logic [COUNT_W-1:0] RST_KEY_COUNT  = 4'd2;
	localparam logic [HOLD_W-1:0]  RST_HOLD_MS    = 16'd50;

	// input word, held in the input stage
	typedef struct packed {
		logic [1:0]          kind;
		logic [ETYPE_W-1:0]  event_type;
		logic [CODE_W-1:0]   key_code;
		logic [VALUE_W-1:0]  key_value;
		logic [MAX_KEYS-1:0] snapshot_mask;
	} item_t;

	// result word; visible lands in bit 0 of m_tdata
	typedef struct packed {
		logic                combo_held;
		logic [MAX_KEYS-1:0] held_mask;
		logic                toggled;
		logic                visible;
	} result_t;

endpackage

/* src/hotkey_combo_hold_detector.sv */
// ----------------------------------------------------------------------------
// hotkey_combo_hold_detector
// Tracks a configured key combination and toggles a visibility flag on hold.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) takes one word per item: s_tuser is the kind (key
//   event, 1 ms tick, key-state snapshot), s_tdata carries the event fields.
//   Master stream (m_*) returns exactly one result word per input word, in
//   order: visibility flag, toggle strobe, held-key mask and combo state.
//   Config channel (cfg_*) writes key code pairs, key count and hold time;
//   it is always ready and is meant to be used while the block is idle.
// Path: an accepted word passes the input stage, then the result register,
//   which is where all key/counter state updates; m_tvalid rises once the
//   word reaches the result register.
// Throughput: one word per cycle while m_tready stays high; the only loop is
//   the state update through eight code comparators, a priority pick and the 16-bit hold compare.
// Reset: held mask, combo state and hold counter clear, visible comes up 1,
//   registers take their defaults (slots 0/1 = codes 54/67, count 2, 50 ms).
// Stall: with m_tready low the result register holds; one more word is
//   taken into the input stage, then s_tready drops until the result moves.
// ----------------------------------------------------------------------------
module hotkey_combo_hold_detector
	import hkchd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// config write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [PAIR_W-1:0]     cfg_data,
	// item stream in
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // event_type[15:0], key_code[25:16],
	                                        // key_value[27:26], snapshot_mask[35:28]
	input  logic [1:0]            s_tuser,  // kind[1:0]
	// result stream out
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // visible[0], toggled[1],
	                                        // held_mask[9:2], combo_held[10]
);

	// config registers
	logic [PAIR_W-1:0]  key_pair_q [4];
	logic [COUNT_W-1:0] key_count_q;
	logic [HOLD_W-1:0]  hold_ms_q;

	// detector state
	logic [MAX_KEYS-1:0] held_q;
	logic                combo_on_q;
	logic                fired_q;
	logic [HOLD_W-1:0]   hold_cnt_q;
	logic                visible_q;

	// input stage and result register
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    res_valid_q;

	logic advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = res_valid_q;
	assign m_tdata   = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_q};

	// ---- config writes ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pair_q[0] <= RST_KEY_PAIR_0;
			key_pair_q[1] <= '0;
			key_pair_q[2] <= '0;
			key_pair_q[3] <= '0;
			key_count_q   <= RST_KEY_COUNT;
			hold_ms_q     <= RST_HOLD_MS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KEY_PAIR_0: key_pair_q[0] <= cfg_data;
				CFG_KEY_PAIR_1: key_pair_q[1] <= cfg_data;
				CFG_KEY_PAIR_2: key_pair_q[2] <= cfg_data;
				CFG_KEY_PAIR_3: key_pair_q[3] <= cfg_data;
				CFG_KEY_COUNT:  key_count_q   <= cfg_data[COUNT_W-1:0];
				CFG_HOLD_MS:    hold_ms_q     <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- input stage ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind          <= s_tuser;
			item_s1.event_type    <= s_tdata[15:0];
			item_s1.key_code      <= s_tdata[25:16];
			item_s1.key_value     <= s_tdata[27:26];
			item_s1.snapshot_mask <= s_tdata[35:28];
		end
	end

	// ---- state update logic ----
	logic [MAX_KEYS-1:0] need;
	logic [MAX_KEYS-1:0] match;
	logic [MAX_KEYS-1:0] first_hit;
	logic [MAX_KEYS-1:0] held_nxt;
	logic [HOLD_W-1:0]   cnt_tick;
	logic [HOLD_W-1:0]   cnt_nxt;
	logic                all_held;
	logic                combo_nxt;
	logic                fired_nxt;
	logic                toggle;

	// active slot mask; counts of 8 and up select every slot
	always_comb begin
		need = '0;
		for (int i = 0; i < MAX_KEYS; i++) begin
			need[i] = (key_count_q > COUNT_W'(i));
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_KEYS; i++) begin
			match[i] = need[i] && (key_pair_q[i/2][(i%2)*CODE_W +: CODE_W] == item_s1.key_code);
		end
		first_hit = match & (~match + MAX_KEYS'(1));  // lowest matching slot
	end

	always_comb begin
		held_nxt = held_q;
		cnt_tick = hold_cnt_q;
		case (item_s1.kind)
			KIND_KEY: begin
				if (item_s1.event_type == ETYPE_KEY) begin
					if (item_s1.key_value != '0) held_nxt = held_q | first_hit;
					else                         held_nxt = held_q & ~first_hit;
				end
			end
			KIND_TICK: begin
				if (hold_cnt_q != '1) cnt_tick = hold_cnt_q + HOLD_W'(1);
			end
			KIND_SNAP: begin
				held_nxt = item_s1.snapshot_mask & need;
			end
			default: ;
		endcase
	end

	always_comb begin
		all_held  = ((held_nxt & need) == need);
		combo_nxt = combo_on_q;
		fired_nxt = fired_q;
		cnt_nxt   = cnt_tick;
		toggle    = 1'b0;
		if (all_held) begin
			if (!combo_on_q) begin
				// new hold: restart the count
				combo_nxt = 1'b1;
				fired_nxt = 1'b0;
				cnt_nxt   = '0;
			end else if (!fired_q && (cnt_tick >= hold_ms_q)) begin
				fired_nxt = 1'b1;
				toggle    = 1'b1;
			end
		end else begin
			combo_nxt = 1'b0;
			fired_nxt = 1'b0;
		end
	end

	// ---- state and result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			combo_on_q  <= 1'b0;
			fired_q     <= 1'b0;
			hold_cnt_q  <= '0;
			visible_q   <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				held_q     <= held_nxt;
				combo_on_q <= combo_nxt;
				fired_q    <= fired_nxt;
				hold_cnt_q <= cnt_nxt;
				visible_q  <= visible_q ^ toggle;
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.visible    <= visible_q ^ toggle;
			res_q.toggled    <= toggle;
			res_q.held_mask  <= held_nxt;
			res_q.combo_held <= combo_nxt;
		end
	end

	// ---- assertions ----
	a_fired_needs_combo: assert property (@(posedge clk) disable iff (!arst_n)
		fired_q |-> combo_on_q)
		else $error("fire mark set without an active hold");

	a_toggle_in_combo: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.toggled) |-> (res_q.combo_held && fired_q))
		else $error("toggle reported outside a held combination");

	a_toggle_flips: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && toggle) |=> (visible_q != $past(visible_q)))
		else $error("toggle did not flip the visible flag");

	a_flag_steady: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(visible_q) && $stable(held_q) && $stable(hold_cnt_q))
		else $error("state changed without a processed word");

endmodule
